// ===== rtl/cfm_pkg.sv =====
// Shared types, constants and reset values for the capture frequency meter.
package cfm_pkg;

  localparam int WINDOW_DEPTH = 10;
  localparam int SLOT_W       = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int FILL_W       = 5;
  localparam int CAP_W        = 16;
  localparam int PERIOD_W     = 17;
  localparam int RATE_W       = 22;
  localparam int GAIN_W       = 16;
  localparam int FREQ_W       = 30;
  localparam int SUM_W        = 34;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 22;

  // Serial divider: SUM_W-bit dividend, PERIOD_W-bit divisor.
  localparam int DIV_N        = SUM_W;
  localparam int DIV_CNT_W    = $clog2(DIV_N);

  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = 1;
  localparam int QCNT_W       = 2;

  localparam logic              RST_ENABLE   = 1'b1;
  localparam logic [RATE_W-1:0] RST_TICKRATE = RATE_W'(1000000);
  localparam logic [GAIN_W-1:0] RST_GAIN     = GAIN_W'(7140);
  localparam logic [RATE_W-1:0] RST_OK_LOW   = RATE_W'(45);
  localparam logic [RATE_W-1:0] RST_OK_HIGH  = RATE_W'(180);
  localparam logic [RATE_W-1:0] RST_ERR_LOW  = RATE_W'(40);
  localparam logic [RATE_W-1:0] RST_ERR_HIGH = RATE_W'(200);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE   = 3'd0,
    CFG_TICKRATE = 3'd1,
    CFG_GAIN     = 3'd2,
    CFG_OK_LOW   = 3'd3,
    CFG_OK_HIGH  = 3'd4,
    CFG_ERR_LOW  = 3'd5,
    CFG_ERR_HIGH = 3'd6
  } cfg_idx_t;

  typedef enum logic {
    KIND_CAPTURE = 1'b0,
    KIND_RESTART = 1'b1
  } kind_t;

  typedef enum logic {
    OP_MEASURE = 1'b0,
    OP_RESTART = 1'b1
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [PERIOD_W-1:0] period;
  } job_t;

  typedef struct packed {
    logic              enable;
    logic [RATE_W-1:0] tick_rate;
    logic [GAIN_W-1:0] gain;
    logic [RATE_W-1:0] ok_low;
    logic [RATE_W-1:0] ok_high;
    logic [RATE_W-1:0] err_low;
    logic [RATE_W-1:0] err_high;
  } cfg_t;

  typedef struct packed {
    logic                start;
    logic [DIV_N-1:0]    dividend;
    logic [PERIOD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_N-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== rtl/cfm_front.sv =====
// Front end: accepts items, pairs captures and queues measure or restart jobs.
module cfm_front import cfm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_kind,
  input  logic [CAP_W-1:0] in_capture_value,
  input  logic             enable,
  input  logic             q_full,
  output logic             push,
  output job_t             push_job
);

  logic             have_first_r, have_first_nxt;
  logic [CAP_W-1:0] first_r;
  logic [CAP_W-1:0] diff;
  logic             accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign diff     = in_capture_value - first_r;

  always_comb begin
    have_first_nxt  = have_first_r;
    push            = 1'b0;
    push_job.op     = OP_MEASURE;
    // equal captures mean one full wrap of the timer
    push_job.period = (diff == '0) ? PERIOD_W'(1 << CAP_W) : {1'b0, diff};
    if (accept) begin
      if (kind_t'(in_kind) == KIND_RESTART) begin
        have_first_nxt = 1'b0;
        push           = 1'b1;
        push_job.op    = OP_RESTART;
      end else if (enable) begin
        have_first_nxt = !have_first_r;
        push           = have_first_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_first_r <= 1'b0;
    end else begin
      have_first_r <= have_first_nxt;
    end
  end

  // hold the first capture of a pair
  always_ff @(posedge clk) begin
    if (accept && kind_t'(in_kind) == KIND_CAPTURE && enable && !have_first_r) begin
      first_r <= in_capture_value;
    end
  end

endmodule

// ===== rtl/cfm_queue.sv =====
// Short job queue between the front end and the back end.
module cfm_queue import cfm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  output logic pop_valid,
  input  logic pop,
  output job_t pop_job
);

  job_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_r, rptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push, do_pop;

  assign full      = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_job   = mem_r[rptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) wptr_r <= wptr_r + 1'b1;
      if (do_pop)  rptr_r <= rptr_r + 1'b1;
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_job;
    end
  end

endmodule

// ===== rtl/cfm_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
module cfm_div import cfm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [PERIOD_W-1:0]  rem_r;
  logic [PERIOD_W-1:0]  dvs_r;
  logic [DIV_N-1:0]     quo_r;
  logic [PERIOD_W:0]    shifted;
  logic [PERIOD_W:0]    trial;
  logic                 qbit;

  assign shifted = {rem_r, quo_r[DIV_N-1]};
  assign trial   = shifted - {1'b0, dvs_r};
  assign qbit    = !trial[PERIOD_W];

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_N - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end else if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end
    end
  end

  // shift the dividend out at the top while quotient bits enter at the bottom
  always_ff @(posedge clk) begin
    if (busy_r) begin
      rem_r <= qbit ? trial[PERIOD_W-1:0] : shifted[PERIOD_W-1:0];
      quo_r <= {quo_r[DIV_N-2:0], qbit};
    end else if (req.start) begin
      rem_r <= '0;
      dvs_r <= req.divisor;
      quo_r <= req.dividend;
    end
  end

endmodule

// ===== rtl/cfm_back.sv =====
// Back end: frequency, calibration, averaging window, band flags and result register.
module cfm_back import cfm_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  cfg_t                cfg,
  input  logic                q_valid,
  input  job_t                q_job,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [PERIOD_W-1:0] out_period_ticks,
  output logic [FREQ_W-1:0]   out_avg_freq_q8,
  output logic [FILL_W-1:0]   out_window_fill,
  output logic                out_ok_signal,
  output logic                out_error_signal,
  output logic                out_ready_res
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_FDIV   = 7'b0000010,
    S_MUL    = 7'b0000100,
    S_UPD    = 7'b0001000,
    S_ASTART = 7'b0010000,
    S_ADIV   = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_t;

  state_t                    state_r, state_nxt;
  logic [PERIOD_W-1:0]       period_r;
  logic [FREQ_W-1:0]         raw_r;
  logic [FREQ_W-1:0]         corr_r;
  logic [FREQ_W-1:0]         win_r [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0]   vld_r;
  logic [SLOT_W-1:0]         slot_r;
  logic [FILL_W-1:0]         fill_r;
  logic [SUM_W-1:0]          sum_r;
  logic                      ready_r;
  logic [FREQ_W-1:0]         old_val;
  logic [SUM_W-1:0]          sum_nxt;
  logic [FILL_W-1:0]         fill_nxt;
  logic [FREQ_W+GAIN_W-1:0]  product;
  logic [FREQ_W-1:0]         avg;
  logic                      ok_flag, err_flag;
  logic                      out_free;
  logic                      out_valid_r;
  div_req_t                  div_req;
  div_rsp_t                  div_rsp;

  cfm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign product   = raw_r * cfg.gain;
  assign avg       = div_rsp.quotient[FREQ_W-1:0];
  assign old_val   = vld_r[slot_r] ? win_r[slot_r] : '0;
  assign sum_nxt   = sum_r - SUM_W'(old_val) + SUM_W'(corr_r);
  assign fill_nxt  = (fill_r < FILL_W'(WINDOW_DEPTH)) ? fill_r + 1'b1 : fill_r;

  assign ok_flag  = (avg > {cfg.ok_low, 8'h00}) && (avg < {cfg.ok_high, 8'h00});
  assign err_flag = !ok_flag &&
                    ((avg < {cfg.err_low, 8'h00}) || (avg > {cfg.err_high, 8'h00}));

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = SUM_W'({cfg.tick_rate, 8'h00});
    div_req.divisor  = q_job.period;
    if (state_r == S_ASTART) begin
      div_req.start    = 1'b1;
      div_req.dividend = sum_r;
      div_req.divisor  = PERIOD_W'(fill_r);
    end else if (state_r == S_IDLE && q_valid && q_job.op == OP_MEASURE) begin
      div_req.start = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid && q_job.op == OP_MEASURE) state_nxt = S_FDIV;
      end
      S_FDIV: begin
        if (div_rsp.done) state_nxt = S_MUL;
      end
      S_MUL:    state_nxt = S_UPD;
      S_UPD:    state_nxt = S_ASTART;
      S_ASTART: state_nxt = S_ADIV;
      S_ADIV: begin
        if (div_rsp.done) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vld_r       <= '0;
      slot_r      <= '0;
      fill_r      <= '0;
      sum_r       <= '0;
      ready_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_IDLE && q_valid && q_job.op == OP_RESTART) begin
        vld_r   <= '0;
        slot_r  <= '0;
        fill_r  <= '0;
        sum_r   <= '0;
        ready_r <= 1'b0;
      end
      if (state_r == S_UPD) begin
        vld_r[slot_r] <= 1'b1;
        slot_r        <= (slot_r == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_r + 1'b1;
        fill_r        <= fill_nxt;
        sum_r         <= sum_nxt;
        if (fill_nxt >= FILL_W'(WINDOW_DEPTH)) ready_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && q_valid) period_r <= q_job.period;
    if (state_r == S_FDIV && div_rsp.done) raw_r <= div_rsp.quotient[FREQ_W-1:0];
    if (state_r == S_MUL) corr_r <= product[FREQ_W+GAIN_W-1:GAIN_W];
    if (state_r == S_UPD) win_r[slot_r] <= corr_r;
    if (state_r == S_OUT && out_free) begin
      out_period_ticks <= period_r;
      out_avg_freq_q8  <= avg;
      out_window_fill  <= fill_r;
      out_ok_signal    <= ok_flag;
      out_error_signal <= err_flag;
      out_ready_res    <= ready_r;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(WINDOW_DEPTH))
    else $error("window fill beyond depth");

  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    ready_r |-> fill_r == FILL_W'(WINDOW_DEPTH))
    else $error("ready flag set with window not full");

  a_empty_sum: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r == '0 |-> sum_r == '0 && vld_r == '0)
    else $error("empty window holds data");

  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && q_valid && q_job.op == OP_RESTART) |=>
      (fill_r == '0 && !ready_r && state_r == S_IDLE))
    else $error("restart did not clear the window");

endmodule

// ===== rtl/capture_frequency_meter.sv =====
// Top level of the capture frequency meter: configuration registers and block wiring.
//
// Input channel (in_valid/in_ready): in_kind selects a timer capture or a restart;
// captures are paired without overlap, and every second capture of a pair yields
// one result on the out_ channel (out_valid/out_ready). Restarts, first captures
// and captures taken while measuring is disabled give no result.
// Configuration (cfg_valid/cfg_ready, always ready) writes register cfg_index
// with cfg_wdata; write only while the block is idle.
// Processing: from acceptance to result a completed pair takes two passes of the
// shared one-bit-per-cycle divider (one for tick_rate*256/period, one for the
// window average) plus the gain multiply, window update and result load. One
// pair is worked on at a time.
// A two-entry job queue lets the front end keep accepting items while the back
// end computes or while a finished result waits; when the receiver stalls, the
// result is held in the output register and the queue fills, then in_ready drops.
// Reset (synchronous, active low) restores register defaults and empties the
// window, the queue and the pairing state; a restart item clears the window and
// the pairing state but neither the queue nor the registers.
module capture_frequency_meter import cfm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_kind,
  input  logic [CAP_W-1:0]      in_capture_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PERIOD_W-1:0]   out_period_ticks,
  output logic [FREQ_W-1:0]     out_avg_freq_q8,
  output logic [FILL_W-1:0]     out_window_fill,
  output logic                  out_ok_signal,
  output logic                  out_error_signal,
  output logic                  out_ready_res,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t cfg_r;
  logic q_full, q_push, q_valid, q_pop;
  job_t push_job, pop_job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable    <= RST_ENABLE;
      cfg_r.tick_rate <= RST_TICKRATE;
      cfg_r.gain      <= RST_GAIN;
      cfg_r.ok_low    <= RST_OK_LOW;
      cfg_r.ok_high   <= RST_OK_HIGH;
      cfg_r.err_low   <= RST_ERR_LOW;
      cfg_r.err_high  <= RST_ERR_HIGH;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ENABLE:   cfg_r.enable    <= cfg_wdata[0];
        CFG_TICKRATE: cfg_r.tick_rate <= cfg_wdata[RATE_W-1:0];
        CFG_GAIN:     cfg_r.gain      <= cfg_wdata[GAIN_W-1:0];
        CFG_OK_LOW:   cfg_r.ok_low    <= cfg_wdata[RATE_W-1:0];
        CFG_OK_HIGH:  cfg_r.ok_high   <= cfg_wdata[RATE_W-1:0];
        CFG_ERR_LOW:  cfg_r.err_low   <= cfg_wdata[RATE_W-1:0];
        CFG_ERR_HIGH: cfg_r.err_high  <= cfg_wdata[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  cfm_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_capture_value (in_capture_value),
    .enable           (cfg_r.enable),
    .q_full           (q_full),
    .push             (q_push),
    .push_job         (push_job)
  );

  cfm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (push_job),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_job   (pop_job)
  );

  cfm_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_valid          (q_valid),
    .q_job            (pop_job),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_period_ticks (out_period_ticks),
    .out_avg_freq_q8  (out_avg_freq_q8),
    .out_window_fill  (out_window_fill),
    .out_ok_signal    (out_ok_signal),
    .out_error_signal (out_error_signal),
    .out_ready_res    (out_ready_res)
  );

endmodule
